// File: hdl/polyline_laplacian_smoother_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyline Laplacian smoother
// Shared property wrappers with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_LAPLACIAN_SMOOTHER_UNIT_ASSERT_SVH
`define POLYLINE_LAPLACIAN_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PLS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pls assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pls assertion failed");

`endif

// File: hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Constants, types, microprogram and arithmetic helpers of the smoother.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int MAX_POINTS     = 64;
    localparam int COORD_BITS     = 32;
    localparam int FIELD_BITS     = 32;
    localparam int IDX_BITS       = $clog2(MAX_POINTS);
    localparam int CNT_BITS       = $clog2(MAX_POINTS + 1);
    localparam int RELAX_BITS     = 17;
    localparam int ITER_BITS      = 16;
    localparam int RELAX_SHIFT    = 17;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 17;
    localparam int DIFF_BITS      = COORD_BITS + 2;
    localparam int PROD_BITS      = DIFF_BITS + RELAX_BITS + 1;
    localparam int SUM_BITS       = COORD_BITS + 4;
    localparam int WIDE_BITS      = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int PC_BITS        = 4;

    localparam logic [RELAX_BITS-1:0] RELAX_ONE   = RELAX_BITS'(65536);
    localparam logic [RELAX_BITS-1:0] RELAX_RESET = RELAX_BITS'(655);
    localparam logic [ITER_BITS-1:0]  ITER_RESET  = ITER_BITS'(100);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELAXATION      = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ITERATION_COUNT = CFG_INDEX_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [FIELD_BITS-1:0] t_field;

    // Read address sources.
    localparam logic [2:0] RA_ZERO  = 3'd0;
    localparam logic [2:0] RA_ONE   = 3'd1;
    localparam logic [2:0] RA_TWO   = 3'd2;
    localparam logic [2:0] RA_AHEAD = 3'd3;
    localparam logic [2:0] RA_K     = 3'd4;

    // Window capture targets.
    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_PREV = 2'd1;
    localparam logic [1:0] CAP_CUR  = 2'd2;
    localparam logic [1:0] CAP_NEXT = 2'd3;

    // Jump conditions: the jump is taken when the condition holds.
    localparam logic [2:0] C_NONE       = 3'd0;
    localparam logic [2:0] C_ALWAYS     = 3'd1;
    localparam logic [2:0] C_WAIT_FINAL = 3'd2;
    localparam logic [2:0] C_SKIP       = 3'd3;
    localparam logic [2:0] C_MORE       = 3'd4;
    localparam logic [2:0] C_OUT_BUSY   = 3'd5;
    localparam logic [2:0] C_K_MORE     = 3'd6;

    // Program steps.
    localparam logic [PC_BITS-1:0] PC_IDLE = 4'd0;
    localparam logic [PC_BITS-1:0] PC_PASS = 4'd1;
    localparam logic [PC_BITS-1:0] PC_P1   = 4'd2;
    localparam logic [PC_BITS-1:0] PC_P2   = 4'd3;
    localparam logic [PC_BITS-1:0] PC_L0   = 4'd4;
    localparam logic [PC_BITS-1:0] PC_L1   = 4'd5;
    localparam logic [PC_BITS-1:0] PC_L2   = 4'd6;
    localparam logic [PC_BITS-1:0] PC_L3   = 4'd7;
    localparam logic [PC_BITS-1:0] PC_L4   = 4'd8;
    localparam logic [PC_BITS-1:0] PC_PEND = 4'd9;
    localparam logic [PC_BITS-1:0] PC_E0   = 4'd10;
    localparam logic [PC_BITS-1:0] PC_E1   = 4'd11;
    localparam logic [PC_BITS-1:0] PC_E2   = 4'd12;
    localparam logic [PC_BITS-1:0] PC_FIN  = 4'd13;
    localparam logic [PC_BITS-1:0] PC_LAST = PC_FIN;

    typedef struct packed {
        logic [2:0]         raddr_sel;
        logic [1:0]         cap;
        logic               diff;
        logic               mult;
        logic               update;
        logic               shift;
        logic               set_j;
        logic               clr_k;
        logic               dec_iter;
        logic               load_out;
        logic               clr_line;
        logic               load_iter;
        logic [2:0]         cond;
        logic [PC_BITS-1:0] target;
    } t_uword;

    typedef struct packed {
        logic [1:0] cap;
        logic       diff;
        logic       mult;
        logic       update;
        logic       shift;
    } t_lane_ctrl;

    typedef struct packed {
        logic                we;
        logic                wsel_input;
        logic [IDX_BITS-1:0] waddr;
        logic [IDX_BITS-1:0] raddr;
    } t_mem_ctrl;

    typedef struct packed {
        logic load;
        logic eol;
        logic ovf;
    } t_emit;

    // Control store. Each interior point takes steps L0 to L4.
    function automatic t_uword uprog(input logic [PC_BITS-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_IDLE: begin
                w.load_iter = 1'b1;
                w.cond      = C_WAIT_FINAL;
                w.target    = PC_IDLE;
            end
            PC_PASS: begin
                w.raddr_sel = RA_ZERO;
                w.clr_k     = 1'b1;
                w.cond      = C_SKIP;
                w.target    = PC_E0;
            end
            PC_P1: begin
                w.raddr_sel = RA_ONE;
                w.cap       = CAP_PREV;
            end
            PC_P2: begin
                w.raddr_sel = RA_TWO;
                w.cap       = CAP_CUR;
                w.set_j     = 1'b1;
            end
            PC_L0: begin
                w.cap = CAP_NEXT;
            end
            PC_L1: begin
                w.diff = 1'b1;
            end
            PC_L2: begin
                w.mult = 1'b1;
            end
            PC_L3: begin
                w.update = 1'b1;
            end
            PC_L4: begin
                w.shift     = 1'b1;
                w.raddr_sel = RA_AHEAD;
                w.cond      = C_MORE;
                w.target    = PC_L0;
            end
            PC_PEND: begin
                w.dec_iter = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = PC_PASS;
            end
            PC_E0: begin
                w.raddr_sel = RA_K;
            end
            PC_E1: begin
                w.raddr_sel = RA_K;
                w.load_out  = 1'b1;
                w.cond      = C_OUT_BUSY;
                w.target    = PC_E1;
            end
            PC_E2: begin
                w.cond   = C_K_MORE;
                w.target = PC_E0;
            end
            PC_FIN: begin
                w.clr_line = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = PC_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    // Clamp an input field to the coordinate range.
    function automatic t_coord sat_input(input t_field f);
        logic signed [WIDE_BITS-1:0]     w;
        logic [WIDE_BITS-COORD_BITS:0]   hi;
        t_coord                          r;
        w  = WIDE_BITS'(f);
        hi = w[WIDE_BITS-1:COORD_BITS-1];
        if (hi == '0 || hi == '1) begin
            r = t_coord'(w);
        end else if (w[WIDE_BITS-1]) begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // Clamp an updated coordinate to the coordinate range.
    function automatic t_coord sat_sum(input logic signed [SUM_BITS-1:0] v);
        logic [SUM_BITS-COORD_BITS:0] hi;
        t_coord                       r;
        hi = v[SUM_BITS-1:COORD_BITS-1];
        if (hi == '0 || hi == '1) begin
            r = t_coord'(v);
        end else if (v[SUM_BITS-1]) begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // Result fields carry the low bits of the sign-extended coordinate.
    function automatic t_field to_field(input t_coord c);
        return FIELD_BITS'(c);
    endfunction

endpackage

// File: hdl/pls_point_if.sv
// ----------------------------------------------------------------------------
// pls_point_if
// Input point channel: one transaction carries one polyline point.
// ----------------------------------------------------------------------------
interface pls_point_if import pls_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field coord_x;
    t_field coord_y;
    t_field coord_z;
    logic   final_point;

    modport source (output valid, coord_x, coord_y, coord_z, final_point, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, final_point, output ready);
endinterface

// File: hdl/pls_result_if.sv
// ----------------------------------------------------------------------------
// pls_result_if
// Result channel: one transaction carries one smoothed point.
// ----------------------------------------------------------------------------
interface pls_result_if import pls_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field smooth_x;
    t_field smooth_y;
    t_field smooth_z;
    logic   end_of_line;
    logic   overflowed;

    modport source (output valid, smooth_x, smooth_y, smooth_z, end_of_line, overflowed,
                    input ready);
    modport sink   (input valid, smooth_x, smooth_y, smooth_z, end_of_line, overflowed,
                    output ready);
endinterface

// File: hdl/pls_cfg_if.sv
// ----------------------------------------------------------------------------
// pls_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pls_cfg_if import pls_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/pls_lane.sv
// ----------------------------------------------------------------------------
// pls_lane
// One axis of the relaxation datapath: a three-point window, the second
// difference, the relaxation product and the rounded, saturated update.
// ----------------------------------------------------------------------------
module pls_lane import pls_pkg::*; (
    input  logic                  i_clk,
    input  logic [RELAX_BITS-1:0] i_relax,
    input  t_lane_ctrl            i_ctrl,
    input  t_coord                i_rdata,
    output t_coord                o_new
);
    t_coord                       r_prev, r_cur, r_next, r_new;
    logic signed [DIFF_BITS-1:0]  r_d, n_d;
    logic signed [PROD_BITS-1:0]  r_prod, n_prod, w_round;
    logic signed [SUM_BITS-1:0]   w_sum;

    assign n_d     = DIFF_BITS'(r_prev) + DIFF_BITS'(r_next) - (DIFF_BITS'(r_cur) <<< 1);
    assign n_prod  = PROD_BITS'($signed({1'b0, i_relax})) * PROD_BITS'(r_d);
    // Rounds to nearest with halves toward plus infinity.
    assign w_round = (r_prod + PROD_BITS'(65536)) >>> RELAX_SHIFT;
    assign w_sum   = SUM_BITS'(r_cur) + SUM_BITS'(w_round);

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cap)
            CAP_PREV: r_prev <= i_rdata;
            CAP_CUR:  r_cur  <= i_rdata;
            CAP_NEXT: r_next <= i_rdata;
            default:  ;
        endcase
        if (i_ctrl.diff) begin
            r_d <= n_d;
        end
        if (i_ctrl.mult) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.update) begin
            r_new <= sat_sum(w_sum);
        end
        if (i_ctrl.shift) begin
            r_prev <= r_new;
            r_cur  <= r_next;
        end
    end

    assign o_new = r_new;
endmodule

// File: hdl/pls_seq.sv
// ----------------------------------------------------------------------------
// pls_seq
// Microcoded sequencer: step counter, control store, line and pass counters.
// ----------------------------------------------------------------------------
module pls_seq import pls_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_final,
    input  logic                 i_out_free,
    input  logic [ITER_BITS-1:0] i_iter_cfg,
    output logic                 o_in_ready,
    output t_mem_ctrl            o_mem,
    output t_lane_ctrl           o_lane,
    output t_emit                o_emit
);
    `include "polyline_laplacian_smoother_unit_assert.svh"

    logic [PC_BITS-1:0]   r_pc, n_pc;
    logic [CNT_BITS-1:0]  r_count;
    logic                 r_drop;
    logic [IDX_BITS-1:0]  r_j;
    logic [CNT_BITS-1:0]  r_k;
    logic [ITER_BITS-1:0] r_iter;
    t_uword               w_uw;
    logic                 w_jump;
    logic                 w_room;
    logic                 w_write_in;
    logic                 w_load;

    assign w_uw       = uprog(r_pc);
    assign o_in_ready = (r_pc == PC_IDLE);
    assign w_room     = (r_count < CNT_BITS'(MAX_POINTS));
    assign w_write_in = i_accept && w_room;
    assign w_load     = w_uw.load_out && i_out_free;

    always_comb begin
        case (w_uw.cond)
            C_ALWAYS:     w_jump = 1'b1;
            C_WAIT_FINAL: w_jump = !(i_accept && i_final);
            C_SKIP:       w_jump = (r_iter == '0) || (r_count < CNT_BITS'(3));
            C_MORE:       w_jump = (CNT_BITS'(r_j) + CNT_BITS'(2)) < r_count;
            C_OUT_BUSY:   w_jump = !i_out_free;
            C_K_MORE:     w_jump = (r_k < r_count);
            default:      w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + PC_BITS'(1);
    end

    always_comb begin
        o_mem.we         = w_write_in || w_uw.shift;
        o_mem.wsel_input = !w_uw.shift;
        o_mem.waddr      = w_uw.shift ? r_j : r_count[IDX_BITS-1:0];
        case (w_uw.raddr_sel)
            RA_ONE:   o_mem.raddr = IDX_BITS'(1);
            RA_TWO:   o_mem.raddr = IDX_BITS'(2);
            RA_AHEAD: o_mem.raddr = r_j + IDX_BITS'(2);
            RA_K:     o_mem.raddr = r_k[IDX_BITS-1:0];
            default:  o_mem.raddr = '0;
        endcase
        o_lane.cap    = w_uw.cap;
        o_lane.diff   = w_uw.diff;
        o_lane.mult   = w_uw.mult;
        o_lane.update = w_uw.update;
        o_lane.shift  = w_uw.shift;
        o_emit.load   = w_load;
        o_emit.eol    = ((r_k + CNT_BITS'(1)) == r_count);
        o_emit.ovf    = r_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_j     <= '0;
            r_k     <= '0;
            r_iter  <= '0;
        end else begin
            r_pc <= n_pc;
            if (i_accept) begin
                if (w_room) begin
                    r_count <= r_count + CNT_BITS'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (w_uw.load_iter && i_accept && i_final) begin
                r_iter <= i_iter_cfg;
            end
            if (w_uw.dec_iter) begin
                r_iter <= r_iter - ITER_BITS'(1);
            end
            if (w_uw.set_j) begin
                r_j <= IDX_BITS'(1);
            end else if (w_uw.shift) begin
                r_j <= r_j + IDX_BITS'(1);
            end
            if (w_uw.clr_k) begin
                r_k <= '0;
            end else if (w_load) begin
                r_k <= r_k + CNT_BITS'(1);
            end
            if (w_uw.clr_line) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    // The program counter stays inside the control store.
    `PLS_ASSERT_NOW(a_pc_in_program, i_clk, i_rst_n, 1'b1, r_pc <= PC_LAST)
    // The point loop only runs on lines with an interior point.
    `PLS_ASSERT_NOW(a_loop_has_interior, i_clk, i_rst_n,
                    r_pc >= PC_L0 && r_pc <= PC_L4, r_count >= CNT_BITS'(3))
    // The point being written always has a right neighbour in the line.
    `PLS_ASSERT_NOW(a_write_inside_line, i_clk, i_rst_n, w_uw.shift,
                    (CNT_BITS'(r_j) + CNT_BITS'(1)) < r_count && r_j != '0)
    // Emission never runs past the stored points.
    `PLS_ASSERT_NOW(a_emit_inside_line, i_clk, i_rst_n, w_load, r_k < r_count)
    // A finished pass always returns to the pass head.
    `PLS_ASSERT_NEXT(a_pass_returns, i_clk, i_rst_n, r_pc == PC_PEND, r_pc == PC_PASS)
endmodule

// File: hdl/polyline_laplacian_smoother_unit.sv
// ----------------------------------------------------------------------------
// polyline_laplacian_smoother_unit
// Relaxed Laplacian smoothing of a 3D polyline in signed Q16.16.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Transaction                         Ready rule
//   i_point    in   one point, final_point ends a line  high in the load step
//   o_result   out  one smoothed point per stored point output register
//   i_cfg      in   write relaxation or iteration_count always high
//
// Loading takes one point per cycle while the sequencer is idle; points
// are written into three coordinate RAMs at the fill count. After the
// final point a line of n points gets P passes of smoothing when n is at
// least three, each run by the five-step microprogram loop per interior
// point through the shared address of the single read port; the points
// are then emitted through steps E0, E1 and E2 each, and the FIN step
// finishes the line. Reset clears the sequencer, the fill count and the
// output valid; the RAMs have no clearing pass. A stalled result holds in
// the output register and the sequencer waits in its emit step.
//
module polyline_laplacian_smoother_unit import pls_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pls_point_if.sink    i_point,
    pls_result_if.source o_result,
    pls_cfg_if.sink      i_cfg
);
    // Configuration registers. Relaxation above one saturates at one.
    logic [RELAX_BITS-1:0] r_relax;
    logic [ITER_BITS-1:0]  r_iter_cfg;
    logic [RELAX_BITS-1:0] w_relax_wr;

    assign i_cfg.ready = 1'b1;
    assign w_relax_wr  = i_cfg.data[RELAX_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax    <= RELAX_RESET;
            r_iter_cfg <= ITER_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_RELAXATION: begin
                    r_relax <= (w_relax_wr > RELAX_ONE) ? RELAX_ONE : w_relax_wr;
                end
                CFG_ITERATION_COUNT: begin
                    r_iter_cfg <= i_cfg.data[ITER_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // Sequencer: it owns the program counter and all line bookkeeping.
    logic       w_in_ready;
    logic       w_accept;
    logic       w_out_free;
    t_mem_ctrl  w_mem;
    t_lane_ctrl w_lane;
    t_emit      w_emit;
    logic       r_out_valid;

    assign i_point.ready = w_in_ready;
    assign w_accept      = i_point.valid && w_in_ready;
    assign w_out_free    = !r_out_valid || o_result.ready;

    pls_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_final    (i_point.final_point),
        .i_out_free (w_out_free),
        .i_iter_cfg (r_iter_cfg),
        .o_in_ready (w_in_ready),
        .o_mem      (w_mem),
        .o_lane     (w_lane),
        .o_emit     (w_emit)
    );

    // Coordinate stores, one per axis, sharing the sequencer's addresses.
    // A RAM write takes either the incoming point or the lane's update.
    logic [COORD_BITS-1:0] w_rd_x, w_rd_y, w_rd_z;
    logic [COORD_BITS-1:0] w_wr_x, w_wr_y, w_wr_z;
    t_coord                w_new_x, w_new_y, w_new_z;

    assign w_wr_x = w_mem.wsel_input ? sat_input(i_point.coord_x) : w_new_x;
    assign w_wr_y = w_mem.wsel_input ? sat_input(i_point.coord_y) : w_new_y;
    assign w_wr_z = w_mem.wsel_input ? sat_input(i_point.coord_z) : w_new_z;

    pls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_wr_x),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rd_x)
    );

    pls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_wr_y),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rd_y)
    );

    pls_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_z (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_wr_z),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rd_z)
    );

    // Three identical lanes run the same control word in lockstep.
    pls_lane u_lane_x (
        .i_clk   (i_clk),
        .i_relax (r_relax),
        .i_ctrl  (w_lane),
        .i_rdata (t_coord'(w_rd_x)),
        .o_new   (w_new_x)
    );

    pls_lane u_lane_y (
        .i_clk   (i_clk),
        .i_relax (r_relax),
        .i_ctrl  (w_lane),
        .i_rdata (t_coord'(w_rd_y)),
        .o_new   (w_new_y)
    );

    pls_lane u_lane_z (
        .i_clk   (i_clk),
        .i_relax (r_relax),
        .i_ctrl  (w_lane),
        .i_rdata (t_coord'(w_rd_z)),
        .o_new   (w_new_z)
    );

    // Output register. It loads from the RAM read data in the emit step and
    // frees itself when the downstream side takes the transaction.
    t_field r_smooth_x, r_smooth_y, r_smooth_z;
    logic   r_eol, r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_smooth_x <= to_field(t_coord'(w_rd_x));
            r_smooth_y <= to_field(t_coord'(w_rd_y));
            r_smooth_z <= to_field(t_coord'(w_rd_z));
            r_eol      <= w_emit.eol;
            r_ovf      <= w_emit.ovf;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.smooth_x    = r_smooth_x;
    assign o_result.smooth_y    = r_smooth_y;
    assign o_result.smooth_z    = r_smooth_z;
    assign o_result.end_of_line = r_eol;
    assign o_result.overflowed  = r_ovf;
endmodule

// File: tb/sv/polyline_laplacian_smoother_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_laplacian_smoother_unit_tb
// Self-checking bench for the relaxed Laplacian polyline smoother. Lines of
// Q16.16 points are streamed in, every accepted point is mirrored into a
// scoreboard that smooths the line itself, and every smoothed point that
// comes out is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module polyline_laplacian_smoother_unit_tb;
    import pls_pkg::*;

    // Clock period is 12 ns, so each half period is 6 ns.
    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 12;
    // Cycles to let the sequencer finish its closing steps after the last
    // smoothed point of a line has been taken.
    localparam int          SETTLE_CYCLES = 20;
    // The slowest correct run is dominated by one three-point line smoothed
    // with 65535 passes; the limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          RANDOM_ITEMS  = 200;
    localparam int          MIN_PHASES    = 4;

    localparam t_field FIELD_MAX = t_field'({1'b0, {(FIELD_BITS-1){1'b1}}});
    localparam t_field FIELD_MIN = t_field'({1'b1, {(FIELD_BITS-1){1'b0}}});

    localparam longint COORD_HI   = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO   = -COORD_HI - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (RELAX_SHIFT - 1);

    // One smoothed point as the result channel should deliver it.
    typedef struct {
        t_field x;
        t_field y;
        t_field z;
        logic   eol;
        logic   ovf;
    } t_smoothed_point;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the loaded line and of the two
    // registers, smooths a line when its final point is accepted, and queues
    // the points that the block must then emit.
    // ------------------------------------------------------------------------
    class smoothing_scoreboard;
        t_smoothed_point       awaited_points[$];
        t_coord                line_x[MAX_POINTS];
        t_coord                line_y[MAX_POINTS];
        t_coord                line_z[MAX_POINTS];
        int unsigned           stored;
        bit                    dropped;
        logic [RELAX_BITS-1:0] relax;
        logic [ITER_BITS-1:0]  passes;
        int unsigned           errors;
        int unsigned           results_seen;

        function new();
            stored       = 0;
            dropped      = 1'b0;
            relax        = RELAX_RESET;
            passes       = ITER_RESET;
            errors       = 0;
            results_seen = 0;
        endfunction

        function t_coord clamp_coord(input longint v);
            if (v > COORD_HI) begin
                return t_coord'(COORD_HI);
            end
            if (v < COORD_LO) begin
                return t_coord'(COORD_LO);
            end
            return t_coord'(v);
        endfunction

        // Relaxation factor times (midpoint - point), rounded to nearest with
        // halves going up; d is twice that distance, hence the extra shift bit.
        function t_coord relax_toward_mid(input t_coord prev, input t_coord cur,
                                          input t_coord next);
            longint d;
            longint step;
            d    = longint'(prev) + longint'(next) - 2 * longint'(cur);
            step = (longint'(relax) * d + ROUND_HALF) >>> RELAX_SHIFT;
            return clamp_coord(longint'(cur) + step);
        endfunction

        function void write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                     input logic [CFG_DATA_BITS-1:0]  data);
            if (idx == CFG_RELAXATION) begin
                relax = (data > RELAX_ONE) ? RELAX_ONE : data[RELAX_BITS-1:0];
            end else if (idx == CFG_ITERATION_COUNT) begin
                passes = data[ITER_BITS-1:0];
            end
        endfunction

        function void note_point(input t_field fx, input t_field fy, input t_field fz,
                                 input logic fin);
            t_smoothed_point sp;
            int unsigned     n;
            if (stored < MAX_POINTS) begin
                line_x[stored] = clamp_coord(longint'(fx));
                line_y[stored] = clamp_coord(longint'(fy));
                line_z[stored] = clamp_coord(longint'(fz));
                stored++;
            end else begin
                dropped = 1'b1;
            end
            if (!fin) begin
                return;
            end
            n = stored;
            if (n >= 3) begin
                for (int unsigned p = 0; p < passes; p++) begin
                    for (int unsigned j = 1; j + 1 < n; j++) begin
                        line_x[j] = relax_toward_mid(line_x[j-1], line_x[j], line_x[j+1]);
                        line_y[j] = relax_toward_mid(line_y[j-1], line_y[j], line_y[j+1]);
                        line_z[j] = relax_toward_mid(line_z[j-1], line_z[j], line_z[j+1]);
                    end
                end
            end
            for (int unsigned k = 0; k < n; k++) begin
                sp.x   = t_field'(line_x[k]);
                sp.y   = t_field'(line_y[k]);
                sp.z   = t_field'(line_z[k]);
                sp.eol = (k + 1 == n);
                sp.ovf = dropped;
                awaited_points.push_back(sp);
            end
            stored  = 0;
            dropped = 1'b0;
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(input t_field x, input t_field y, input t_field z,
                          input logic eol, input logic ovf);
            t_smoothed_point want;
            results_seen++;
            if (awaited_points.size() == 0) begin
                report($sformatf("result %0d arrived with no point expected", results_seen));
                return;
            end
            want = awaited_points.pop_front();
            if (x !== want.x) begin
                report($sformatf("result %0d smooth_x %h, expected %h", results_seen, x, want.x));
            end
            if (y !== want.y) begin
                report($sformatf("result %0d smooth_y %h, expected %h", results_seen, y, want.y));
            end
            if (z !== want.z) begin
                report($sformatf("result %0d smooth_z %h, expected %h", results_seen, z, want.z));
            end
            if (eol !== want.eol) begin
                report($sformatf("result %0d end_of_line %b, expected %b",
                                 results_seen, eol, want.eol));
            end
            if (ovf !== want.ovf) begin
                report($sformatf("result %0d overflowed %b, expected %b",
                                 results_seen, ovf, want.ovf));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    pls_point_if  point_ch();
    pls_result_if result_ch();
    pls_cfg_if    cfg_ch();

    smoothing_scoreboard board = new();

    // Random idling on each side can be switched off for a stretch.
    bit          sender_gaps   = 1'b1;
    bit          receiver_gaps = 1'b1;
    // Set by the stimulus to have the receiver hold off once results appear.
    bit          hold_request  = 1'b0;
    int          random_items  = 0;
    int unsigned cycle_count   = 0;

    polyline_laplacian_smoother_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (point_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driving tasks. All inputs change with nonblocking assignments right
    // after a rising edge, and ready is read in the same step, before the
    // block's registers move, so each transaction is seen as the block saw it.
    // ------------------------------------------------------------------------

    // Offers one point and returns at the edge where the transaction happens.
    // Valid stays high on return so that a following point can go straight
    // out; whoever stops sending must lower it in that same step.
    task automatic offer_point(input t_field x, input t_field y, input t_field z,
                               input logic fin);
        while (sender_gaps && $urandom_range(99) < 10) begin
            point_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        point_ch.valid       <= 1'b1;
        point_ch.coord_x     <= x;
        point_ch.coord_y     <= y;
        point_ch.coord_z     <= z;
        point_ch.final_point <= fin;
        @(posedge i_clk);
        while (!point_ch.ready) begin
            @(posedge i_clk);
        end
        board.note_point(x, y, z, fin);
    endtask

    // Writes both registers back to back; the first write keeps valid high
    // into the second, which drops it once it has been taken.
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] relax_data,
                              input logic [CFG_DATA_BITS-1:0] iter_data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_RELAXATION;
        cfg_ch.data  <= relax_data;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        board.write_register(CFG_RELAXATION, relax_data);
        cfg_ch.index <= CFG_ITERATION_COUNT;
        cfg_ch.data  <= iter_data;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        board.write_register(CFG_ITERATION_COUNT, iter_data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering points, then waits until every predicted point has come
    // out and the sequencer has had time to clear the line.
    task automatic wait_idle();
        point_ch.valid <= 1'b0;
        while (board.awaited_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Coordinates lean on the range ends, zero and minus one; the rest are
    // fully random so that every bit of each field toggles.
    function automatic t_field pick_coord();
        case ($urandom_range(9))
            0:       return FIELD_MAX;
            1:       return FIELD_MIN;
            2:       return '0;
            3:       return '1;
            default: return t_field'($urandom);
        endcase
    endfunction

    // Sends one line of n points. Half the lines are noisy, the other half
    // follow a straight track with small jitter, the way a sampled centerline
    // usually looks.
    task automatic send_random_line(input int n);
        bit     shaped;
        t_field base_x;
        t_field base_y;
        t_field base_z;
        t_field step;
        t_field x;
        t_field y;
        t_field z;
        shaped = $urandom_range(1);
        base_x = pick_coord();
        base_y = pick_coord();
        base_z = pick_coord();
        step   = t_field'($urandom_range(0, 32'h0004_0000)) - t_field'(32'h0002_0000);
        for (int i = 0; i < n; i++) begin
            if (shaped) begin
                x = base_x + step * i + t_field'($urandom_range(0, 4095)) - 2048;
                y = base_y - step * i + t_field'($urandom_range(0, 4095)) - 2048;
                z = base_z + t_field'($urandom_range(0, 65535)) - 32768;
            end else begin
                x = pick_coord();
                y = pick_coord();
                z = pick_coord();
            end
            offer_point(x, y, z, i == n - 1);
            random_items++;
        end
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_relaxation();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_DATA_BITS'(RELAX_ONE);
            2:       return '1;
            3:       return CFG_DATA_BITS'(32768);
            4:       return CFG_DATA_BITS'($urandom_range(1, 2000));
            default: return CFG_DATA_BITS'($urandom);
        endcase
    endfunction

    // Pass counts stay small so that long lines remain cheap; bit 16 of the
    // write data lies outside the register and is set at random.
    function automatic logic [CFG_DATA_BITS-1:0] pick_iterations();
        logic [ITER_BITS-1:0] count;
        if ($urandom_range(9) == 0) begin
            count = ITER_BITS'($urandom_range(20, 40));
        end else begin
            count = ITER_BITS'($urandom_range(0, 8));
        end
        return {1'($urandom_range(1)), count};
    endfunction

    // Mostly short lines, some of one or two points, and now and then a line
    // near the store size that may fill it and run past it.
    function automatic int pick_line_length();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return $urandom_range(MAX_POINTS - 4, MAX_POINTS + 6);
        end else if (r < 20) begin
            return $urandom_range(1, 2);
        end
        return $urandom_range(3, 12);
    endfunction

    // ------------------------------------------------------------------------
    // Result side. Every transaction on the result channel is checked, ready
    // idles at random, and once in the run it is held low for a long count
    // of cycles while the sender keeps offering the next line.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                board.check_result(result_ch.smooth_x, result_ch.smooth_y,
                                   result_ch.smooth_z, result_ch.end_of_line,
                                   result_ch.overflowed);
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_request && result_ch.valid === 1'b1) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
            end else if (receiver_gaps && $urandom_range(99) < 10) begin
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that outlasts the limit is a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        i_rst_n              = 1'b0;
        point_ch.valid       = 1'b0;
        point_ch.coord_x     = '0;
        point_ch.coord_y     = '0;
        point_ch.coord_z     = '0;
        point_ch.final_point = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_RELAXATION;
        cfg_ch.data          = '0;
        result_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (small relaxation, 100 passes). A three-point line
        // swinging between the range ends, then a line of one point and a
        // line of two points, which must both come back unchanged.
        offer_point(FIELD_MAX, FIELD_MIN, '0, 1'b0);
        offer_point(FIELD_MIN, FIELD_MAX, '1, 1'b0);
        offer_point(FIELD_MAX, FIELD_MIN, t_field'(32'h0001_0000), 1'b1);
        offer_point(t_field'(32'h1234_5678), t_field'(32'h8765_4321), '0, 1'b1);
        offer_point(FIELD_MIN, FIELD_MAX, t_field'(1), 1'b0);
        offer_point('1, '0, FIELD_MIN, 1'b1);
        wait_idle();

        // A relaxation write above one clamps to one; zero passes leave the
        // line as loaded.
        set_config('1, CFG_DATA_BITS'(32'h1_0000));
        for (int i = 0; i < 4; i++) begin
            offer_point(pick_coord(), pick_coord(), pick_coord(), i == 3);
        end
        wait_idle();

        // Full relaxation with the largest pass count on the shortest line
        // that gets smoothed.
        set_config(CFG_DATA_BITS'(RELAX_ONE), '1);
        offer_point(FIELD_MIN, FIELD_MAX, '0, 1'b0);
        offer_point(FIELD_MAX, FIELD_MIN, '1, 1'b0);
        offer_point(FIELD_MIN, FIELD_MAX, t_field'(32'h7fff_0000), 1'b1);
        wait_idle();

        // Zero relaxation: passes run but nothing moves.
        set_config('0, CFG_DATA_BITS'(1));
        for (int i = 0; i < 4; i++) begin
            offer_point(pick_coord(), pick_coord(), pick_coord(), i == 3);
        end
        wait_idle();

        // Smallest nonzero relaxation: small differences round to a zero step, wide ones still move.
        set_config(CFG_DATA_BITS'(1), CFG_DATA_BITS'(3));
        offer_point('0, '0, '0, 1'b0);
        offer_point(t_field'(32'h0000_ffff), t_field'(-32'sd65535), t_field'(32'h0002_0000), 1'b0);
        offer_point(FIELD_MAX, FIELD_MIN, '1, 1'b0);
        offer_point(t_field'(32'h0001_0000), '1, FIELD_MAX, 1'b1);
        wait_idle();

        // Random part: phases of a few lines each under fresh settings. One
        // phase runs with no idling on either side, another holds the result
        // side off long enough that the block stops taking points. At least
        // four phases run so that both of those always come round.
        phase = 0;
        while (random_items < RANDOM_ITEMS || phase < MIN_PHASES) begin
            set_config(pick_relaxation(), pick_iterations());
            sender_gaps   = (phase != 2);
            receiver_gaps = (phase != 2);
            if (phase == 3) begin
                hold_request = 1'b1;
            end
            repeat ($urandom_range(3, 6)) begin
                send_random_line(pick_line_length());
            end
            wait_idle();
            phase++;
        end

        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
